FILE: design/fcom_pkg.sv
// Shared constants, codes and fixed-point helpers for the fly camera unit.
`timescale 1ns / 1ps
`default_nettype none
package fcom_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam int XY_W  = 34;   // CORDIC x/y, Q2.30 plus headroom
  localparam int Z_W   = 32;   // CORDIC residual angle, degrees*2^16
  localparam int MA_W  = 18;
  localparam int MB_W  = 33;
  localparam int MP_W  = MA_W + MB_W;

  localparam logic signed [15:0] ANG_180   = 16'sd11520;
  localparam logic signed [15:0] ANG_90    = 16'sd5760;
  localparam logic signed [18:0] ANG_360   = 19'sd23040;
  localparam logic signed [18:0] PITCH_LIM = 19'sd5696;
  localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
  localparam logic [15:0]        FOV_FLOOR = 16'd256;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [15:0] YAW_RST   = -16'sd5760;
  localparam logic [15:0]        FOV_RST   = 16'd11520;
  localparam logic [15:0]        SENS_RST  = 16'd6554;
  localparam logic [15:0]        SPEED_RST = 16'd640;
  localparam logic [15:0]        CEIL_RST  = 16'd11520;

  localparam logic [1:0] MODE_LOOK = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_ZOOM = 2'd2;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] CFG_SENS  = 2'd0;
  localparam logic [1:0] CFG_SPEED = 2'd1;
  localparam logic [1:0] CFG_CEIL  = 2'd2;

  // atan(2^-i) in degrees*2^16
  function automatic logic signed [Z_W-1:0] atan_deg16(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q2.28 product to Q1.14 and clamp to +-1.0
  function automatic logic signed [15:0] q14_round(input logic signed [MP_W-1:0] p);
    logic signed [MP_W-1:0] t;
    t = (p + MP_W'(8192)) >>> 14;
    if (t > MP_W'(16384))
      return ONE_Q14;
    else if (t < -MP_W'(16384))
      return -ONE_Q14;
    else
      return t[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/fly_camera_orientation_motion.sv
// Top level of the fly camera unit: sequencer, shared multiplier and camera state.
// Each request yields one result holding the whole camera state after it. A look
// request repeats the 360-degree wrap step until yaw and pitch are in range, then
// runs the CORDIC unit, shared by yaw and pitch, once for each. A move forms the
// velocity product, then updates each position component in turn, then presents
// the result: three components forward or backward, two left or right. A zoom
// updates the field of view and presents the result. One request is in flight at
// a time; in_ready is low meanwhile and rises in the cycle after the result loads.
// After reset the unit builds its vectors from the reset angles before it raises
// in_ready.
`timescale 1ns / 1ps
`default_nettype none
module fly_camera_orientation_motion
  import fcom_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [15:0] in_x_offset,
  input  wire logic signed [15:0] in_y_offset,
  input  wire logic               in_constrain_pitch,
  input  wire logic [1:0]         in_direction,
  input  wire logic [15:0]        in_delta_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_fov_out,
  output logic signed [15:0]      out_front_x,
  output logic signed [15:0]      out_front_y,
  output logic signed [15:0]      out_front_z,
  output logic signed [15:0]      out_right_x,
  output logic signed [15:0]      out_right_z,
  output logic signed [15:0]      out_up_x,
  output logic signed [15:0]      out_up_y,
  output logic signed [15:0]      out_up_z,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_LK0 = 5'd1,  S_LK1 = 5'd2,  S_LK2 = 5'd3,
                         S_WRAP = 5'd4,  S_CY  = 5'd5,  S_CYW = 5'd6,  S_CP  = 5'd7,
                         S_CPW  = 5'd8,  S_M1  = 5'd9,  S_M2  = 5'd10, S_M3  = 5'd11,
                         S_M4   = 5'd12, S_M5  = 5'd13, S_M6  = 5'd14, S_M7  = 5'd15,
                         S_MV0  = 5'd16, S_MV1 = 5'd17, S_MV2 = 5'd18, S_MV3 = 5'd19,
                         S_ZM   = 5'd20, S_DONE = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic       init_r;

  logic [15:0] sens_r, speed_r, ceil_r;
  logic [1:0]  dir_r;
  logic signed [15:0] xo_r, yo_r;
  logic        con_r;
  logic [15:0] dt_r;

  logic signed [15:0] yaw_r, pitch_r;
  logic [15:0]        fov_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] fx_r, fy_r, fz_r, rx_r, rz_r, ux_r, uy_r, uz_r;
  logic signed [15:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [18:0] ysum_r, psum_r;
  logic [31:0]        vel_r;
  logic [1:0]         k_r;
  logic signed [MP_W-1:0] p_r, t_r;
  logic               out_valid_r;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] p_nxt;

  logic               cor_start, cor_busy, cor_done;
  logic signed [15:0] cor_angle, cor_s, cor_c;

  logic signed [15:0] rx_c, rz_c, comp_c;
  logic signed [18:0] look_d, psum_c;
  logic signed [21:0] fov_c;
  logic signed [MP_W-1:0] step_c;
  logic signed [33:0] pos_sum;
  logic               sub_c, ysum_ok, psum_ok, out_load;

  fcom_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (cor_angle),
    .busy    (cor_busy),
    .done    (cor_done),
    .sin_q14 (cor_s),
    .cos_q14 (cor_c)
  );

  assign cor_start = (state_r == S_CY) || (state_r == S_CP);
  assign cor_angle = (state_r == S_CY) ? yaw_r : pitch_r;

  // right flips with the sign of cos pitch; zero counts as positive
  assign rx_c = (cp_r < 0) ? sy_r : -sy_r;
  assign rz_c = (cp_r < 0) ? -cy_r : cy_r;

  assign look_d = 19'((p_r + MP_W'(8192)) >>> 14);

  always_comb begin
    psum_c = 19'(pitch_r) + look_d;
    if (con_r) begin
      if (psum_c > PITCH_LIM)
        psum_c = PITCH_LIM;
      else if (psum_c < -PITCH_LIM)
        psum_c = -PITCH_LIM;
    end
  end

  assign ysum_ok = (ysum_r >= -19'(ANG_180)) && (ysum_r < 19'(ANG_180));
  assign psum_ok = (psum_r >= -19'(ANG_180)) && (psum_r < 19'(ANG_180));

  always_comb begin
    case (k_r)
      2'd0:    comp_c = (dir_r == DIR_FWD || dir_r == DIR_BACK) ? fx_r : rx_r;
      2'd1:    comp_c = fy_r;
      default: comp_c = (dir_r == DIR_FWD || dir_r == DIR_BACK) ? fz_r : rz_r;
    endcase
  end

  assign sub_c   = (dir_r == DIR_BACK) || (dir_r == DIR_LEFT);
  assign step_c  = (p_r + MP_W'(2097152)) >>> 22;
  assign pos_sum = sub_c ? (34'(pos_r[k_r]) - 34'(step_c))
                         : (34'(pos_r[k_r]) + 34'(step_c));

  always_comb begin
    fov_c = $signed({6'b0, fov_r}) - (22'(yo_r) <<< 4);
    if (fov_c < $signed({6'b0, FOV_FLOOR}))
      fov_c = $signed({6'b0, FOV_FLOOR});
    if (fov_c > $signed({6'b0, ceil_r}))
      fov_c = $signed({6'b0, ceil_r});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LK0: begin
        mul_a = MA_W'(xo_r);
        mul_b = $signed({17'b0, sens_r});
      end
      S_LK1: begin
        mul_a = MA_W'(yo_r);
        mul_b = $signed({17'b0, sens_r});
      end
      S_M1: begin
        mul_a = MA_W'(cy_r);
        mul_b = MB_W'(cp_r);
      end
      S_M2: begin
        mul_a = MA_W'(sy_r);
        mul_b = MB_W'(cp_r);
      end
      S_M3: begin
        mul_a = -MA_W'(rz_c);
        mul_b = MB_W'(sp_r);
      end
      S_M4: begin
        mul_a = MA_W'(rz_r);
        mul_b = MB_W'(fx_r);
      end
      S_M5: begin
        mul_a = MA_W'(rx_r);
        mul_b = MB_W'(fz_r);
      end
      S_M6: begin
        mul_a = MA_W'(rx_r);
        mul_b = MB_W'(fy_r);
      end
      S_MV0: begin
        mul_a = $signed({2'b0, speed_r});
        mul_b = $signed({17'b0, dt_r});
      end
      S_MV2: begin
        mul_a = MA_W'(comp_c);
        mul_b = $signed({1'b0, vel_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_nxt = MP_W'(mul_a) * MP_W'(mul_b);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_LOOK: state_nxt = S_LK0;
            MODE_MOVE: state_nxt = S_MV0;
            MODE_ZOOM: state_nxt = S_ZM;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_LK0:  state_nxt = S_LK1;
      S_LK1:  state_nxt = S_LK2;
      S_LK2:  state_nxt = S_WRAP;
      S_WRAP: if (ysum_ok && psum_ok) state_nxt = S_CY;
      S_CY:   state_nxt = S_CYW;
      S_CYW:  if (cor_done) state_nxt = S_CP;
      S_CP:   state_nxt = S_CPW;
      S_CPW:  if (cor_done) state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_M7;
      S_M7:   state_nxt = init_r ? S_IDLE : S_DONE;
      S_MV0:  state_nxt = S_MV1;
      S_MV1:  state_nxt = S_MV2;
      S_MV2:  state_nxt = S_MV3;
      S_MV3:  state_nxt = (k_r == 2'd2) ? S_DONE : S_MV2;
      S_ZM:   state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (in_valid && in_ready) begin
      xo_r   <= in_x_offset;
      yo_r   <= in_y_offset;
      con_r  <= in_constrain_pitch;
      dir_r  <= in_direction;
      dt_r   <= in_delta_time;
    end
    case (state_r)
      S_LK1: ysum_r <= 19'(yaw_r) + look_d;
      S_LK2: psum_r <= psum_c;
      S_WRAP: begin
        if (ysum_r >= 19'(ANG_180))
          ysum_r <= ysum_r - ANG_360;
        else if (ysum_r < -19'(ANG_180))
          ysum_r <= ysum_r + ANG_360;
        if (psum_r >= 19'(ANG_180))
          psum_r <= psum_r - ANG_360;
        else if (psum_r < -19'(ANG_180))
          psum_r <= psum_r + ANG_360;
      end
      S_CYW: begin
        sy_r <= cor_s;
        cy_r <= cor_c;
      end
      S_CPW: begin
        sp_r <= cor_s;
        cp_r <= cor_c;
      end
      S_M2: begin
        fx_r <= q14_round(p_r);
        fy_r <= sp_r;
      end
      S_M3: begin
        fz_r <= q14_round(p_r);
        rx_r <= rx_c;
        rz_r <= rz_c;
      end
      S_M4: ux_r <= q14_round(p_r);
      S_M5: t_r  <= p_r;
      S_M6: uy_r <= q14_round(t_r - p_r);
      S_M7: uz_r <= q14_round(p_r);
      S_MV1: begin
        vel_r <= p_r[31:0];
        k_r   <= 2'd0;
      end
      S_MV3: begin
        // right has no y part; skip it
        k_r <= (k_r == 2'd0 && (dir_r == DIR_LEFT || dir_r == DIR_RIGHT)) ? 2'd2
                                                                            : k_r + 2'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_fov_out <= fov_r;
      out_front_x <= fx_r;
      out_front_y <= fy_r;
      out_front_z <= fz_r;
      out_right_x <= rx_r;
      out_right_z <= rz_r;
      out_up_x    <= ux_r;
      out_up_y    <= uy_r;
      out_up_z    <= uz_r;
      out_pos_x   <= pos_r[0];
      out_pos_y   <= pos_r[1];
      out_pos_z   <= pos_r[2];
    end
    if (!rst_n) begin
      state_r     <= S_CY;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      sens_r      <= SENS_RST;
      speed_r     <= SPEED_RST;
      ceil_r      <= CEIL_RST;
      yaw_r       <= YAW_RST;
      pitch_r     <= '0;
      fov_r       <= FOV_RST;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_M7)
        init_r <= 1'b0;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SENS:  sens_r  <= cfg_wdata;
          CFG_SPEED: speed_r <= cfg_wdata;
          CFG_CEIL:  ceil_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_WRAP && ysum_ok && psum_ok) begin
        yaw_r   <= ysum_r[15:0];
        pitch_r <= psum_r[15:0];
      end
      if (state_r == S_ZM)
        fov_r <= fov_c[15:0];
      if (state_r == S_MV3) begin
        if (pos_sum > 34'sh0_7FFF_FFFF)
          pos_r[k_r] <= 32'sh7FFF_FFFF;
        else if (pos_sum < -34'sh0_8000_0000)
          pos_r[k_r] <= 32'sh8000_0000;
        else
          pos_r[k_r] <= pos_sum[31:0];
      end
    end
  end

  assign out_valid = out_valid_r;

  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cor_start |-> !cor_busy)
    else $error("angle unit restarted while busy");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (yaw_r >= -ANG_180) && (yaw_r < ANG_180))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r >= -ANG_180) && (pitch_r < ANG_180))
    else $error("pitch out of range");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !out_valid_r |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished request not presented");

endmodule
`default_nettype wire

FILE: design/fcom_cordic.sv
// Iterative CORDIC sine/cosine on a Q10.6 degree angle, one rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fcom_cordic
  import fcom_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] angle,
  output logic                    busy,
  output logic                    done,
  output logic signed [15:0]      sin_q14,
  output logic signed [15:0]      cos_q14
);

  localparam int IW = $clog2(STEPS);
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic [IW-1:0]          i_r, i_nxt;
  logic                   neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic signed [15:0]     a_red;
  logic                   a_neg;
  logic signed [XY_W-1:0] xs, ys;

  always_comb begin
    a_neg = 1'b0;
    a_red = angle;
    if (angle > ANG_90) begin
      a_red = angle - ANG_180;
      a_neg = 1'b1;
    end else if (angle < -ANG_90) begin
      a_red = angle + ANG_180;
      a_neg = 1'b1;
    end
  end

  always_comb begin
    xs       = x_r >>> i_r;
    ys       = y_r >>> i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = Z_W'(a_red) <<< 10;
      i_nxt    = '0;
      neg_nxt  = a_neg;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_deg16(5'(i_r));
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_deg16(5'(i_r));
      end
      i_nxt = i_r + 1'b1;
      if (i_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [XY_W-1:0] v,
                                               input logic n);
    logic signed [XY_W-1:0] s;
    logic signed [XY_W-1:0] t;
    s = n ? -v : v;
    t = (s + XY_W'(32768)) >>> 16;
    if (t > XY_W'(16384))
      return ONE_Q14;
    else if (t < -XY_W'(16384))
      return -ONE_Q14;
    else
      return t[15:0];
  endfunction

  assign busy    = busy_r;
  assign done    = done_r;
  assign sin_q14 = to_q14(y_r, neg_r);
  assign cos_q14 = to_q14(x_r, neg_r);

endmodule
`default_nettype wire
